// File: rtl/cbf_pkg.sv
package cbf_pkg;

  // Default geometry
  localparam int INDEX_BITS_DEF   = 16;
  localparam int HASH_COUNT_DEF   = 4;
  localparam int COUNTER_BITS_DEF = 8;

  // FNV-1a, 32 bit
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_MULT  = 32'd16777619;

  // Position multiplier after reset
  localparam logic [31:0] MUL_RESET = 32'd2654435761;

  // Action codes (code 3 behaves as a query)
  localparam logic [1:0] ACT_QUERY  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       empty_key;
  } in_item_t;

  typedef struct packed {
    logic was_present;
    logic store_changed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic fold;      // fold hash into first position seed
    logic gen;       // step position generator, store pos[k]
    logic k_clear;   // position index back to zero (wins over k_step)
    logic k_step;    // advance position index
    logic chk_rd;    // presence read at pos[k]
    logic upd_rd;    // update read at pos[k]
    logic upd_wr;    // update write at pos[k]
    logic clr_step;  // clear one store entry
    logic load_out;  // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_end;   // input transaction ends a key
    logic k_last;    // position index at last position
    logic clr_last;  // clear sweep at last entry
    logic do_update; // counters must be stepped
    logic out_free;  // result register can take a new result
  } status_t;

endpackage

// File: rtl/cbf_ctrl.sv
module cbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cbf_pkg::status_t status,
  output cbf_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_FOLD   = 10'b00_0000_0100,
    S_GEN    = 10'b00_0000_1000,
    S_CHECK  = 10'b00_0001_0000,
    S_SETTLE = 10'b00_0010_0000,
    S_DECIDE = 10'b00_0100_0000,
    S_UPD_RD = 10'b00_1000_0000,
    S_UPD_WR = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; clearing sweep follows reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.key_end) begin
            state_next = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        cmd.fold    = 1'b1;
        cmd.k_clear = 1'b1;
        state_next  = S_GEN;
      end
      S_GEN: begin
        cmd.gen = 1'b1;
        if (status.k_last) begin
          cmd.k_clear = 1'b1;
          state_next  = S_CHECK;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.chk_rd = 1'b1;
        if (status.k_last) begin
          cmd.k_clear = 1'b1;
          state_next  = S_SETTLE;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      S_SETTLE: begin
        // last presence read lands here
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.k_clear = 1'b1;
        if (status.do_update) begin
          state_next = S_UPD_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (status.k_last) begin
          cmd.k_clear = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.k_step = 1'b1;
          state_next = S_UPD_RD;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/cbf_datapath.sv
module cbf_datapath #(
  parameter int INDEX_BITS   = cbf_pkg::INDEX_BITS_DEF,
  parameter int HASH_COUNT   = cbf_pkg::HASH_COUNT_DEF,
  parameter int COUNTER_BITS = cbf_pkg::COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbf_pkg::cmd_t       cmd,
  output cbf_pkg::status_t    status,
  input  cbf_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cbf_pkg::out_item_t  out_data
);

  localparam int KW    = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int DEPTH = 1 << INDEX_BITS;

  logic [31:0]             mul;
  logic [31:0]             hash;
  logic [31:0]             hash_mixed;
  logic [31:0]             hash_prod;
  logic [1:0]              action;
  logic [INDEX_BITS-1:0]   seed;
  logic [INDEX_BITS-1:0]   seed_next;
  logic [2*INDEX_BITS-1:0] seed_prod;
  logic [INDEX_BITS-1:0]   fold_val;
  logic [31:0]             hash_hi;
  logic [INDEX_BITS-1:0]   pos [HASH_COUNT];
  logic [INDEX_BITS-1:0]   pos_cur;
  logic [KW-1:0]           k;
  logic [INDEX_BITS-1:0]   clr_addr;
  logic [COUNTER_BITS-1:0] mem [DEPTH];
  logic [COUNTER_BITS-1:0] rdata;
  logic                    eval_pending;
  logic                    present;
  logic                    changed;
  logic                    step_ok;
  logic [COUNTER_BITS-1:0] step_val;
  logic                    we;
  logic [INDEX_BITS-1:0]   wr_addr;
  logic [COUNTER_BITS-1:0] wr_data;

  // Position multiplier register
  always_ff @(posedge clk) begin
    if (rst) begin
      mul <= cbf_pkg::MUL_RESET;
    end else if (cfg_valid) begin
      mul <= cfg_data;
    end
  end

  // FNV-1a byte step
  assign hash_mixed = hash ^ {24'd0, in_data.key_byte};
  assign hash_prod  = hash_mixed * cbf_pkg::FNV_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= cbf_pkg::FNV_BASIS;
    end else if (cmd.accept) begin
      if (in_data.empty_key) begin
        hash <= cbf_pkg::FNV_BASIS;
      end else begin
        hash <= hash_prod;
      end
    end else if (cmd.fold) begin
      hash <= cbf_pkg::FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action <= in_data.action;
    end
  end

  // Fold and position generator; only the low index bits matter
  assign hash_hi   = hash >> INDEX_BITS;
  assign fold_val  = hash_hi[INDEX_BITS-1:0] ^ hash[INDEX_BITS-1:0];
  assign seed_prod = mul[INDEX_BITS-1:0] * seed;
  assign seed_next = seed_prod[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      seed <= fold_val;
    end else if (cmd.gen) begin
      seed   <= seed_next;
      pos[k] <= seed_next;
    end
  end

  // Position index
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_step) begin
      k <= k + KW'(1);
    end
  end

  assign pos_cur = pos[k];

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + INDEX_BITS'(1);
    end
  end

  // Counter step for the update write
  always_comb begin
    step_ok  = 1'b0;
    step_val = rdata;
    if (action == cbf_pkg::ACT_ADD) begin
      step_ok  = (rdata != '1);
      step_val = rdata + COUNTER_BITS'(1);
    end else if (action == cbf_pkg::ACT_REMOVE) begin
      step_ok  = (rdata != '0);
      step_val = rdata - COUNTER_BITS'(1);
    end
  end

  assign we      = cmd.clr_step | (cmd.upd_wr & step_ok);
  assign wr_addr = cmd.clr_step ? clr_addr : pos_cur;
  assign wr_data = cmd.clr_step ? '0 : step_val;

  // Counter store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_rd | cmd.upd_rd) begin
      rdata <= mem[pos_cur];
    end
  end

  // Presence and change flags
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_pending <= 1'b0;
    end else begin
      eval_pending <= cmd.chk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      present <= 1'b1;
      changed <= 1'b0;
    end else begin
      if (eval_pending && (rdata == '0)) begin
        present <= 1'b0;
      end
      if (cmd.upd_wr && step_ok) begin
        changed <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.was_present   <= present;
      out_data.store_changed <= changed;
    end
  end

  // Status back to the controller
  assign status.key_end   = in_data.empty_key | in_data.last_byte;
  assign status.k_last    = (k == KW'(HASH_COUNT - 1));
  assign status.clr_last  = (clr_addr == '1);
  assign status.do_update = ((action == cbf_pkg::ACT_ADD) && !present)
                          || ((action == cbf_pkg::ACT_REMOVE) && present);
  assign status.out_free  = !out_valid || !out_stall;

endmodule

// File: rtl/counting_bloom_filter.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data  (cbf_pkg::in_item_t)
// out       output     out_valid / out_stall out_data (cbf_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_data (position multiplier)
//
// A key byte that does not end a key is absorbed by one FNV multiply, and the input stays ready.
// The ending transaction folds the hash, generates the positions and reads the store once
// per position, then does one read-modify-write per position when counters are stepped.
// After reset all 2^INDEX_BITS store entries are swept to zero with in_stall high.
// The result register lets the next key's bytes in while a result waits on out_stall.
module counting_bloom_filter #(
  parameter int INDEX_BITS   = cbf_pkg::INDEX_BITS_DEF,
  parameter int HASH_COUNT   = cbf_pkg::HASH_COUNT_DEF,
  parameter int COUNTER_BITS = cbf_pkg::COUNTER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  cbf_pkg::cmd_t    cmd;
  cbf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  cbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cbf_datapath #(
    .INDEX_BITS   (INDEX_BITS),
    .HASH_COUNT   (HASH_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/cbf_checker.sv
module cbf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input cbf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input cbf_pkg::out_item_t out_data
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After a byte inside a key the input is ready again in the next cycle
  a_mid_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.last_byte && !in_data.empty_key |=> !in_stall)
    else $error("input not ready after a mid-key byte");

  // A key end starts the lookup, which holds the input off
  a_key_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.last_byte || in_data.empty_key) |=> in_stall)
    else $error("input ready right after a key end");

  // A new result is only loaded at the end of a lookup
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a lookup");

endmodule

bind counting_bloom_filter cbf_checker u_cbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/tb_counting_bloom_filter.sv
`timescale 1ns / 100ps

module tb_counting_bloom_filter;
  import cbf_pkg::*;

  localparam int IDX_BITS    = INDEX_BITS_DEF;
  localparam int HASH_COUNT  = HASH_COUNT_DEF;
  localparam int CNT_BITS    = COUNTER_BITS_DEF;
  localparam int TABLE_SIZE  = 1 << IDX_BITS;
  localparam bit [31:0] IDX_MASK = (32'd1 << IDX_BITS) - 32'd1;
  localparam bit [CNT_BITS-1:0] CNT_MAX = '1;

  // Spare action code, handled by the block as a query
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Settling wait: covers the worst key end, with some margin
  localparam int SETTLE      = 5 + 4 * HASH_COUNT + 20;
  localparam int CYCLE_LIMIT = 1000000;

  localparam int POOL_SIZE   = 24;
  localparam int MAX_KEY_LEN = 6;

  // Predicts each key's outcome and checks the results in order
  class bloom_scoreboard;
    bit [31:0] multiplier;
    bit [31:0] running_hash;
    bit [CNT_BITS-1:0] tally [TABLE_SIZE];
    out_item_t expected_results[$];
    int errors;

    function new();
      multiplier   = MUL_RESET;
      running_hash = FNV_BASIS;
      errors       = 0;
      foreach (tally[i]) tally[i] = '0;
    endfunction

    function void set_multiplier(bit [31:0] value);
      multiplier = value;
    endfunction

    // One accepted input transaction; queues a result when it ends a key
    function void note_key_item(in_item_t it);
      bit [31:0] h;
      bit [31:0] p;
      bit [IDX_BITS-1:0] pos [HASH_COUNT];
      bit present;
      bit changed;
      out_item_t res;
      if (it.empty_key) begin
        h = FNV_BASIS;
      end else begin
        h = (running_hash ^ {24'd0, it.key_byte}) * FNV_MULT;
        if (!it.last_byte) begin
          running_hash = h;
          return;
        end
      end
      running_hash = FNV_BASIS;

      // fold, then step through the counter positions
      p = (h >> IDX_BITS) ^ (h & IDX_MASK);
      present = 1'b1;
      changed = 1'b0;
      for (int k = 0; k < HASH_COUNT; k++) begin
        p = (multiplier * p) & IDX_MASK;
        pos[k] = p[IDX_BITS-1:0];
        if (tally[pos[k]] == '0) present = 1'b0;
      end

      // repeated positions are stepped once per occurrence
      if (it.action == ACT_ADD && !present) begin
        foreach (pos[k]) begin
          if (tally[pos[k]] != CNT_MAX) begin
            tally[pos[k]] = tally[pos[k]] + 1'b1;
            changed = 1'b1;
          end
        end
      end else if (it.action == ACT_REMOVE && present) begin
        foreach (pos[k]) begin
          if (tally[pos[k]] != '0) begin
            tally[pos[k]] = tally[pos[k]] - 1'b1;
            changed = 1'b1;
          end
        end
      end

      res.was_present   = present;
      res.store_changed = changed;
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing outstanding: was_present %0b store_changed %0b",
               got.was_present, got.store_changed);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.was_present !== want.was_present) begin
        $error("was_present: expected %0b, got %0b", want.was_present, got.was_present);
        errors++;
      end
      if (got.store_changed !== want.store_changed) begin
        $error("store_changed: expected %0b, got %0b", want.store_changed, got.store_changed);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;

  bloom_scoreboard sb;
  bit no_idle;
  int items_sent;
  int unsigned cycle_count;

  bit [7:0] pool_bytes [POOL_SIZE][MAX_KEY_LEN];
  int       pool_len   [POOL_SIZE];

  counting_bloom_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly short, occasionally long
  function automatic int idle_length();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_action(input int add_pct);
    if ($urandom_range(0, 99) < add_pct) return ACT_ADD;
    case ($urandom_range(0, 3))
      0: return ACT_QUERY;
      1: return ACT_UNUSED;
      default: return ACT_REMOVE;
    endcase
  endfunction

  function automatic in_item_t key_item(input logic [1:0] act, input logic [7:0] kb,
                                        input logic last, input logic empty);
    in_item_t it;
    it.action    = act;
    it.key_byte  = kb;
    it.last_byte = last;
    it.empty_key = empty;
    return it;
  endfunction

  // Result side stalls in bursts, with long free-running stretches now and then
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall = 1'b0;
        run_left--;
      end else begin
        out_stall  = 1'b0;
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
        stall_left = idle_length();
      end
    end
  end

  // Transaction monitor: results first, then the input taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_key_item(in_data);
    end
  end

  // Hold one input transaction until the block takes it
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Whole key from the pool; non-final bytes carry a random action
  task automatic send_key(input int slot, input logic [1:0] act);
    if (pool_len[slot] == 0) begin
      send_item(key_item(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
    end else begin
      for (int i = 0; i < pool_len[slot]; i++) begin
        if (i == pool_len[slot] - 1)
          send_item(key_item(act, pool_bytes[slot][i], 1'b1, 1'b0));
        else
          send_item(key_item(pick_action(25), pool_bytes[slot][i], 1'b0, 1'b0));
      end
    end
  endtask

  // A few bytes cut short by an empty-key transaction
  task automatic send_broken();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_item(key_item(pick_action(25), 8'($urandom_range(0, 255)), 1'b0, 1'b0));
    send_item(key_item(pick_action(35), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'b1));
  endtask

  task automatic run_random(input int n_items, input int fresh_pct, input int add_pct,
                            input int max_len);
    int stop_at;
    int slot;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        send_broken();
      end else begin
        slot = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < fresh_pct) begin
          len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, max_len);
          pool_len[slot] = len;
          for (int i = 0; i < len; i++) pool_bytes[slot][i] = 8'($urandom_range(0, 255));
        end
        send_key(slot, pick_action(add_pct));
      end
    end
    drop_valid();
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write, only once the block has gone quiet
  task automatic write_multiplier(input logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_multiplier(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Run timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("counting_bloom_filter: mismatch");
    $finish;
  end

  initial begin
    sb         = new();
    no_idle    = 1'b0;
    items_sent = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    for (int s = 0; s < POOL_SIZE; s++) begin
      pool_len[s] = $urandom_range(0, 4);
      for (int i = 0; i < MAX_KEY_LEN; i++) pool_bytes[s][i] = 8'($urandom_range(0, 255));
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty key through each action, extreme bytes, spare code, discard
    send_item(key_item(ACT_QUERY,  8'h00, 1'b1, 1'b1));
    send_item(key_item(ACT_ADD,    8'h00, 1'b1, 1'b1));
    send_item(key_item(ACT_QUERY,  8'hFF, 1'b0, 1'b1));
    send_item(key_item(ACT_ADD,    8'h5A, 1'b0, 1'b1));
    send_item(key_item(ACT_UNUSED, 8'hFF, 1'b0, 1'b1));
    send_item(key_item(ACT_REMOVE, 8'h00, 1'b1, 1'b1));
    send_item(key_item(ACT_REMOVE, 8'h00, 1'b1, 1'b1));
    send_item(key_item(ACT_ADD,    8'h00, 1'b1, 1'b0));
    send_item(key_item(ACT_ADD,    8'hFF, 1'b1, 1'b0));
    send_item(key_item(ACT_QUERY,  8'hFF, 1'b1, 1'b0));
    send_item(key_item(ACT_UNUSED, 8'h00, 1'b0, 1'b0));
    send_item(key_item(ACT_REMOVE, 8'hFF, 1'b1, 1'b0));
    send_item(key_item(ACT_UNUSED, 8'hA5, 1'b0, 1'b0));
    send_item(key_item(ACT_ADD,    8'h5A, 1'b0, 1'b0));
    send_item(key_item(ACT_ADD,    8'h3C, 1'b0, 1'b1));
    send_item(key_item(ACT_QUERY,  8'hC3, 1'b1, 1'b1));
    send_item(key_item(ACT_REMOVE, 8'hFF, 1'b1, 1'b0));
    send_item(key_item(ACT_REMOVE, 8'hFF, 1'b1, 1'b0));
    send_item(key_item(ACT_UNUSED, 8'h00, 1'b1, 1'b0));
    send_item(key_item(ACT_UNUSED, 8'h80, 1'b0, 1'b0));
    send_item(key_item(ACT_QUERY,  8'h01, 1'b1, 1'b0));
    drop_valid();

    // Random phases across multiplier settings
    write_multiplier(32'hFFFF_FFFF);
    run_random(100, 30, 35, 6);
    write_multiplier(32'd1);
    run_random(70, 30, 35, 4);
    // zero multiplier: every position lands on entry zero
    write_multiplier(32'd0);
    run_random(50, 30, 35, 4);
    // 256 piles three of the four positions onto entry zero, driving it to saturation
    write_multiplier(32'd256);
    run_random(220, 90, 85, 2);
    run_random(80, 10, 15, 2);
    write_multiplier($urandom | 32'd1);
    run_random(120, 30, 35, 6);
    // back-to-back transactions, no input gaps and no result-side stalls
    no_idle = 1'b1;
    write_multiplier(MUL_RESET);
    run_random(100, 30, 35, 5);
    no_idle = 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("counting_bloom_filter: match");
    else
      $display("counting_bloom_filter: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cbf_pkg.sv
rtl/cbf_ctrl.sv
rtl/cbf_datapath.sv
rtl/counting_bloom_filter.sv
rtl/cbf_checker.sv
tb/sv/tb_counting_bloom_filter.sv
